@@ rtl/aipr_pkg.sv @@
// ----------------------------------------------------------------------------
// aipr_pkg
// Types and constants shared by the attitude indicator pixel rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package aipr_pkg;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] column;
  } in_t;

  typedef struct packed {
    logic        in_mask;
    logic [15:0] pixel_color;
  } out_t;

  typedef enum logic [2:0] {
    CFG_COEF_XX  = 3'd0,
    CFG_COEF_XY  = 3'd1,
    CFG_OFFSET_X = 3'd2,
    CFG_COEF_YX  = 3'd3,
    CFG_COEF_YY  = 3'd4,
    CFG_OFFSET_Y = 3'd5
  } cfg_idx_e;

  localparam int CfgIdxW   = 3;
  localparam int CoefW     = 32;
  localparam int ProdW     = 41;  // 32-bit signed times 9-bit non-negative
  localparam int SumW      = 43;
  localparam int FracW     = 16;
  localparam int CoordW    = SumW - FracW;

  localparam logic [31:0] COEF_XX_RST  = 32'sd65536;
  localparam logic [31:0] COEF_XY_RST  = 32'sd0;
  localparam logic [31:0] OFFSET_X_RST = -32'sd6553600;
  localparam logic [31:0] COEF_YX_RST  = 32'sd0;
  localparam logic [31:0] COEF_YY_RST  = -32'sd65536;
  localparam logic [31:0] OFFSET_Y_RST = 32'sd6553600;

  localparam logic [15:0] SKY_COLOR    = 16'h9E5E;
  localparam logic [15:0] GROUND_COLOR = 16'hD520;
  localparam logic [15:0] WHITE_COLOR  = 16'hFFFF;
  localparam logic [15:0] RED_COLOR    = 16'hF800;

  localparam int FACE_SIZE      = 200;
  localparam int FACE_CENTER    = 100;
  localparam int LADDER_HALF    = 20;
  localparam int LADDER_STEP1   = 20;
  localparam int LADDER_STEP2   = 40;
  localparam int HORIZON_HALF   = 2;
  localparam int OVERLAY_ROW_A  = 99;
  localparam int OVERLAY_ROW_B  = 100;
  localparam int OVERLAY_COL_LO = 70;
  localparam int OVERLAY_COL_HI = 130;

  // half chord of the round face for each row of the upper half
  localparam logic [6:0] CHORD_TAB [100] = '{
    7'd14, 7'd20, 7'd24, 7'd28, 7'd31, 7'd34, 7'd37, 7'd39, 7'd41, 7'd44,
    7'd46, 7'd47, 7'd49, 7'd51, 7'd53, 7'd54, 7'd56, 7'd57, 7'd59, 7'd60,
    7'd61, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71,
    7'd72, 7'd73, 7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd78, 7'd79, 7'd80,
    7'd81, 7'd81, 7'd82, 7'd83, 7'd84, 7'd84, 7'd85, 7'd85, 7'd86, 7'd87,
    7'd87, 7'd88, 7'd88, 7'd89, 7'd89, 7'd90, 7'd90, 7'd91, 7'd91, 7'd92,
    7'd92, 7'd92, 7'd93, 7'd93, 7'd94, 7'd94, 7'd94, 7'd95, 7'd95, 7'd95,
    7'd96, 7'd96, 7'd96, 7'd97, 7'd97, 7'd97, 7'd97, 7'd98, 7'd98, 7'd98,
    7'd98, 7'd98, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100
  };

  function automatic logic [6:0] chord_len(input logic [6:0] idx);
    logic [6:0] len;
    len = '0;
    if (idx < 7'd100) begin
      len = CHORD_TAB[idx];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

@@ rtl/attitude_indicator_pixel_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// attitude_indicator_pixel_rasterizer_unit
// Per-pixel mask test, overlay test, affine map and sky/ground/ladder classification.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                 | beat
//   --------+-----------+---------------------------+--------------------------
//   in      | in        | in_valid_i / in_ready_o   | row, column
//   out     | out       | out_valid_o / out_ready_i | in_mask, pixel_color
//   cfg     | in        | cfg_valid_i / cfg_ready_o | register index, data
//
// one beat in and one beat out per cycle while the output is not stalled;
// the four register stages are mask/overlay, four 32x9 multiplier lanes,
// the three-way sum, and classification into the output register.
// reset clears the stage valid bits and loads the matrix reset values.
// a stall at the output holds the full stages from the output back to the
// first bubble; stages behind that bubble still move up and fill it.
// cfg_ready_o is always high.
`default_nettype none

module attitude_indicator_pixel_rasterizer_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire aipr_pkg::in_t             in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output aipr_pkg::out_t                 out_data_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [aipr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]               cfg_data_i
);
  import aipr_pkg::*;

  // configuration
  logic signed [CoefW-1:0] coef_xx_q, coef_xy_q, offset_x_q;
  logic signed [CoefW-1:0] coef_yx_q, coef_yy_q, offset_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q  <= COEF_XX_RST;
      coef_xy_q  <= COEF_XY_RST;
      offset_x_q <= OFFSET_X_RST;
      coef_yx_q  <= COEF_YX_RST;
      coef_yy_q  <= COEF_YY_RST;
      offset_y_q <= OFFSET_Y_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_COEF_XX:  coef_xx_q  <= cfg_data_i;
        CFG_COEF_XY:  coef_xy_q  <= cfg_data_i;
        CFG_OFFSET_X: offset_x_q <= cfg_data_i;
        CFG_COEF_YX:  coef_yx_q  <= cfg_data_i;
        CFG_COEF_YY:  coef_yy_q  <= cfg_data_i;
        CFG_OFFSET_Y: offset_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage enables, back to front
  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // stage 1: mask and overlay
  logic [6:0] chord_idx;
  logic [6:0] chord;
  logic [7:0] lo_col, hi_col;
  logic       mask_d, ovl_d;
  logic [7:0] row_q, col_q;
  logic       mask1_q, ovl1_q;

  always_comb begin
    if (in_data_i.row < 8'(FACE_CENTER)) begin
      chord_idx = in_data_i.row[6:0];
    end else begin
      chord_idx = 7'(8'(FACE_SIZE - 1) - in_data_i.row);
    end
    chord  = chord_len(chord_idx);
    lo_col = 8'(FACE_CENTER) - {1'b0, chord};
    hi_col = 8'(FACE_CENTER) + {1'b0, chord};
    mask_d = (in_data_i.row < 8'(FACE_SIZE)) &&
             (in_data_i.column >= lo_col) && (in_data_i.column < hi_col);
    ovl_d  = ((in_data_i.row == 8'(OVERLAY_ROW_A)) ||
              (in_data_i.row == 8'(OVERLAY_ROW_B))) &&
             (in_data_i.column >= 8'(OVERLAY_COL_LO)) &&
             (in_data_i.column < 8'(OVERLAY_COL_HI));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      row_q   <= in_data_i.row;
      col_q   <= in_data_i.column;
      mask1_q <= mask_d;
      ovl1_q  <= ovl_d;
    end
  end

  // stage 2: multiplier lanes
  logic signed [ProdW-1:0] pxc_d, pxr_d, pyc_d, pyr_d;
  logic signed [ProdW-1:0] pxc_q, pxr_q, pyc_q, pyr_q;
  logic                    mask2_q, ovl2_q;

  assign pxc_d = coef_xx_q * $signed({1'b0, col_q});
  assign pxr_d = coef_xy_q * $signed({1'b0, row_q});
  assign pyc_d = coef_yx_q * $signed({1'b0, col_q});
  assign pyr_d = coef_yy_q * $signed({1'b0, row_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pxc_q   <= pxc_d;
      pxr_q   <= pxr_d;
      pyc_q   <= pyc_d;
      pyr_q   <= pyr_d;
      mask2_q <= mask1_q;
      ovl2_q  <= ovl1_q;
    end
  end

  // stage 3: sums, floor by arithmetic shift
  logic signed [SumW-1:0]   sum_x, sum_y;
  logic signed [CoordW-1:0] sx_q, sy_q;
  logic                     mask3_q, ovl3_q;

  assign sum_x = SumW'(pxc_q) + SumW'(pxr_q) + SumW'(offset_x_q);
  assign sum_y = SumW'(pyc_q) + SumW'(pyr_q) + SumW'(offset_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sx_q    <= sum_x[SumW-1:FracW];
      sy_q    <= sum_y[SumW-1:FracW];
      mask3_q <= mask2_q;
      ovl3_q  <= ovl2_q;
    end
  end

  // stage 4: classification into the output register
  logic        on_ladder;
  logic [15:0] color_d;
  out_t        out_q;

  always_comb begin
    on_ladder = (sx_q >= -LADDER_HALF) && (sx_q <= LADDER_HALF) &&
                ((sy_q == LADDER_STEP1) || (sy_q == LADDER_STEP2) ||
                 (sy_q == -LADDER_STEP1) || (sy_q == -LADDER_STEP2));
    if (!mask3_q) begin
      color_d = '0;
    end else if (ovl3_q) begin
      color_d = RED_COLOR;
    end else if (on_ladder) begin
      color_d = WHITE_COLOR;
    end else if (sy_q > HORIZON_HALF) begin
      color_d = SKY_COLOR;
    end else if (sy_q < -HORIZON_HALF) begin
      color_d = GROUND_COLOR;
    end else begin
      color_d = WHITE_COLOR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      out_q.in_mask     <= mask3_q;
      out_q.pixel_color <= color_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

  // checks
  a_unmasked_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_mask |-> out_data_o.pixel_color == '0)
    else $error("pixel outside the face carries a colour");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v1_q && v2_q && v3_q && v4_q)
    else $error("input blocked with a bubble in the pipe");

  a_stall_keeps_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !out_ready_i |=> v4_q && $stable(out_q))
    else $error("output beat lost under stall");

  a_mask_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && (row_q >= 8'(FACE_SIZE)) |-> !mask1_q)
    else $error("row beyond the face marked inside the mask");

endmodule

`default_nettype wire
